@@ hw/rtl/jkse_pkg.sv @@
package jkse_pkg;

   // Characters that steer the extraction.
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_NUL       = 8'h00;

   // Configuration register indexes.
   localparam logic [1:0] REG_KEY_BYTES  = 2'd0;
   localparam logic [1:0] REG_KEY_LENGTH = 2'd1;
   localparam logic [1:0] REG_MAX_CHARS  = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [63:0] KEY_BYTES_RESET  = 64'd0;
   localparam logic [3:0]  KEY_LENGTH_RESET = 4'd1;
   localparam logic [15:0] MAX_CHARS_RESET  = 16'd255;

   // Depth of the queue between the classifier and the extraction engine.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // One classified text byte.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       is_zero;
      logic       is_quote;
      logic       is_colon;
      logic       is_bslash;
   } item_type;

   // One result item.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       done_res;
      logic       found;
   } result_type;

   // Configuration seen by the extraction engine.
   typedef struct packed {
      logic [63:0] key_bytes;
      logic [3:0]  key_length;
      logic [15:0] max_chars;
   } cfg_type;

endpackage

@@ hw/rtl/jkse_front.sv @@
module jkse_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_last,
   output logic              push_valid,
   input  logic              push_ready,
   output jkse_pkg::item_type push_item
);
   import jkse_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;

   // Take a new item whenever the stage is empty or drains into the queue.
   assign req_ready = !valid_ff || push_ready;

   // Classify the incoming byte.
   always_comb begin
      item_in.data_byte = req_in_byte;
      item_in.last      = req_last;
      item_in.is_zero   = (req_in_byte == CHAR_NUL);
      item_in.is_quote  = (req_in_byte == CHAR_QUOTE);
      item_in.is_colon  = (req_in_byte == CHAR_COLON);
      item_in.is_bslash = (req_in_byte == CHAR_BACKSLASH);
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

@@ hw/rtl/jkse_queue.sv @@
module jkse_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  jkse_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output jkse_pkg::item_type pop_item
);
   import jkse_pkg::*;

   item_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff;
   logic [QUEUE_PTR_BITS:0]   count_in;
   logic                      push;
   logic                      pop;

   assign push_ready = (count_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   // The fill count never goes past the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // The pointers stay apart by exactly the fill count.
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_PTR_BITS-1:0])
      else $error("queue pointers disagree with count");

   // A push without a pop grows the count by one.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");
`endif

endmodule

@@ hw/rtl/jkse_back.sv @@
module jkse_back #(
   parameter int unsigned KEY_MAX_BYTES = 8,
   parameter int unsigned COUNT_BITS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  jkse_pkg::cfg_type  cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  jkse_pkg::item_type pop_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output jkse_pkg::result_type rsp_result
);
   import jkse_pkg::*;

   localparam logic [2:0] PH_SEARCH = 3'd0;
   localparam logic [2:0] PH_COLON  = 3'd1;
   localparam logic [2:0] PH_QUOTE  = 3'd2;
   localparam logic [2:0] PH_COPY   = 3'd3;
   localparam logic [2:0] PH_DRAIN  = 3'd4;

   localparam int unsigned KEY_CAP  = (KEY_MAX_BYTES < 8) ? KEY_MAX_BYTES : 8;
   localparam int unsigned WIDE     = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   logic [2:0]            phase_ff;
   logic [2:0]            phase_in;
   logic [63:0]           recent_ff;
   logic [63:0]           recent_in;
   logic [3:0]            seen_ff;
   logic [3:0]            seen_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  esc_ff;
   logic                  esc_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   result_type            rsp_ff;
   result_type            res;
   logic                  has_res;
   logic                  pop;

   logic [3:0]            key_len;
   logic [WIDE-1:0]       mc_wide;
   logic [WIDE-1:0]       cap_wide;
   logic [COUNT_BITS-1:0] limit;
   logic [63:0]           shifted;
   logic [3:0]            seen_sat;
   logic [7:0]            lane_ok;
   logic                  key_hit;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  copy;
   logic                  done;
   logic                  fnd;

   // The engine moves one item whenever the output register is free or emptying.
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;

   // Effective key length and copy limit from the configuration.
   always_comb begin
      key_len = cfg.key_length;
      if (key_len == 4'd0) begin
         key_len = 4'd1;
      end
      if (key_len > 4'(KEY_CAP)) begin
         key_len = 4'(KEY_CAP);
      end
      mc_wide  = WIDE'(cfg.max_chars);
      cap_wide = WIDE'({COUNT_BITS{1'b1}});
      limit    = (mc_wide > cap_wide) ? cap_wide[COUNT_BITS-1:0]
                                      : mc_wide[COUNT_BITS-1:0];
   end

   // Window match of the last bytes against the key, lane by lane.
   always_comb begin
      shifted  = {recent_ff[55:0], pop_item.data_byte};
      seen_sat = (seen_ff < 4'd8) ? seen_ff + 4'd1 : seen_ff;
      for (int i = 0; i < 8; i++) begin
         lane_ok[i] = (4'(i) >= key_len) ||
                      (shifted[8*i +: 8] == cfg.key_bytes[8*i +: 8]);
      end
      key_hit = (seen_sat >= key_len) && (&lane_ok);
   end

   // Extraction state machine, one item per cycle whenever the output register is free or emptying.
   always_comb begin
      phase_in  = phase_ff;
      recent_in = recent_ff;
      seen_in   = seen_ff;
      count_in  = count_ff;
      esc_in    = esc_ff;
      res       = '0;
      done      = 1'b0;
      fnd       = 1'b0;
      copy      = 1'b0;
      count_inc = count_ff + 1'b1;
      if (phase_ff == PH_DRAIN) begin
         if (pop_item.last) begin
            phase_in = PH_SEARCH;
         end
      end else if (pop_item.is_zero) begin
         if (phase_ff == PH_COPY && esc_ff) begin
            res.byte_valid = 1'b1;
            res.out_byte   = CHAR_BACKSLASH;
         end
         done = 1'b1;
         fnd  = (phase_ff == PH_COPY) && ((count_ff != '0) || esc_ff);
      end else begin
         case (phase_ff)
            PH_SEARCH: begin
               recent_in = shifted;
               seen_in   = seen_sat;
               if (key_hit) begin
                  phase_in = PH_COLON;
               end
               done = pop_item.last;
            end
            PH_COLON: begin
               if (pop_item.is_colon) begin
                  phase_in = PH_QUOTE;
               end
               done = pop_item.last;
            end
            PH_QUOTE: begin
               if (pop_item.is_quote) begin
                  if (limit == '0) begin
                     done = 1'b1;
                  end else begin
                     phase_in = PH_COPY;
                  end
               end
               if (pop_item.last) begin
                  done = 1'b1;
               end
            end
            PH_COPY: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  copy   = 1'b1;
               end else if (pop_item.is_bslash) begin
                  if (pop_item.last) begin
                     copy = 1'b1;
                  end else begin
                     esc_in = 1'b1;
                  end
               end else if (pop_item.is_quote) begin
                  done = 1'b1;
                  fnd  = (count_ff != '0);
               end else begin
                  copy = 1'b1;
               end
               if (copy) begin
                  res.byte_valid = 1'b1;
                  res.out_byte   = pop_item.data_byte;
                  count_in       = count_inc;
                  if ((count_inc >= limit) || pop_item.last) begin
                     done = 1'b1;
                     fnd  = 1'b1;
                  end
               end else if (!done && pop_item.last) begin
                  done = 1'b1;
                  fnd  = (count_ff != '0);
               end
            end
            default: begin
               phase_in = PH_SEARCH;
            end
         endcase
      end
      // Closing a text clears its state and waits for the end if needed.
      if (done || (phase_ff == PH_DRAIN && pop_item.last)) begin
         phase_in  = pop_item.last ? PH_SEARCH : PH_DRAIN;
         recent_in = '0;
         seen_in   = '0;
         count_in  = '0;
         esc_in    = 1'b0;
      end
      res.done_res = done;
      res.found    = done && fnd;
      has_res      = res.byte_valid || done;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = has_res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         recent_ff    <= '0;
         seen_ff      <= '0;
         count_ff     <= '0;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff  <= phase_in;
            recent_ff <= recent_in;
            seen_ff   <= seen_in;
            count_ff  <= count_in;
            esc_ff    <= esc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && has_res) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

`ifndef ASSERT_OFF
   // A result without a byte is always the closing one.
   a_empty_is_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.byte_valid) |-> rsp_ff.done_res)
      else $error("result carries neither byte nor close");

   // Found is only reported on the closing result.
   a_found_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |-> rsp_ff.done_res)
      else $error("found outside the closing result");

   // An escape is only pending while copying.
   a_escape_in_copy: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> (phase_ff == PH_COPY))
      else $error("escape pending outside copy");

   // Outside copying no bytes are counted.
   a_count_in_copy: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_COPY) |-> (count_ff == '0))
      else $error("copy count left over");
`endif

endmodule

@@ hw/rtl/json_key_string_extractor_top.sv @@
// JSON key string extractor. Text enters one byte per req_ item; the block
// finds the first occurrence of the configured key, then the next colon and
// the next double quote, and returns the string bytes that follow as rsp_
// items, resolving backslash escapes. Every text closes with exactly one
// result flagged done, with found set if any byte was copied. The block
// sustains one byte per clock cycle unless rsp_ready stalls: the classifier
// register, a four-entry queue and the extraction engine each move one item
// a cycle, and the key compare is a parallel match over an eight-byte window.
// A byte passes the classifier register, a queue entry and the output
// register. Write the csr_ registers only while no text is in flight.
module json_key_string_extractor_top #(
   parameter int unsigned KEY_MAX_BYTES = 8,
   parameter int unsigned COUNT_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_done_res,
   output logic        rsp_found,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import jkse_pkg::*;

   cfg_type    cfg_ff;
   item_type   push_item;
   item_type   pop_item;
   result_type rsp_result;
   logic       push_valid;
   logic       push_ready;
   logic       pop_valid;
   logic       pop_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_bytes  <= KEY_BYTES_RESET;
         cfg_ff.key_length <= KEY_LENGTH_RESET;
         cfg_ff.max_chars  <= MAX_CHARS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_KEY_BYTES:  cfg_ff.key_bytes  <= csr_wdata;
            REG_KEY_LENGTH: cfg_ff.key_length <= csr_wdata[3:0];
            REG_MAX_CHARS:  cfg_ff.max_chars  <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   jkse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_last    (req_last),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   jkse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   jkse_back #(
      .KEY_MAX_BYTES (KEY_MAX_BYTES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_out_byte   = rsp_result.out_byte;
   assign rsp_byte_valid = rsp_result.byte_valid;
   assign rsp_done_res   = rsp_result.done_res;
   assign rsp_found      = rsp_result.found;

endmodule

@@ dv/tb_json_key_string_extractor_top.sv @@
`timescale 1ns / 100ps

module tb_json_key_string_extractor_top;
   import jkse_pkg::*;

   localparam int RANDOM_BYTES  = 1800;
   localparam int STEADY_BYTES  = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;

   // Where the extraction stands within the current text.
   typedef enum logic [2:0] {
      SEEK_KEY,
      SEEK_COLON,
      SEEK_QUOTE,
      COPYING,
      DRAINING
   } scan_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_done_res;
   logic        rsp_found;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = REG_KEY_BYTES;
   logic [63:0] csr_wdata = '0;

   // Shadow copy of the registers and of the scan state.
   logic [63:0] key_reg = KEY_BYTES_RESET;
   logic [3:0]  key_len_reg = KEY_LENGTH_RESET;
   logic [15:0] max_chars_reg = MAX_CHARS_RESET;
   scan_phase_type scan_phase = SEEK_KEY;
   logic [63:0] window = '0;
   logic [3:0]  window_fill = '0;
   logic [15:0] copy_count = '0;
   logic        escape_armed = 1'b0;

   // Results still owed by the block, and the text being assembled ({last, byte}).
   result_type  owed_q[$];
   logic [8:0]  text_q[$];

   bit idle_on = 1'b0;
   int stall_left = 0;
   int errors = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int texts_closed = 0;
   int strings_found = 0;
   int configs_used = 0;
   int cycle_count = 0;

   json_key_string_extractor_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_done_res   (rsp_done_res),
      .rsp_found      (rsp_found),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   // The key length in use: zero counts as one, anything above eight as eight.
   function automatic int key_span();
      int n;
      n = key_len_reg;
      if (n == 0) n = 1;
      if (n > 8) n = 8;
      return n;
   endfunction

   // End of extraction: go back to the key search, or ignore bytes until the last one.
   function automatic void close_text(input logic is_last);
      scan_phase   = is_last ? SEEK_KEY : DRAINING;
      window       = '0;
      window_fill  = '0;
      copy_count   = '0;
      escape_armed = 1'b0;
   endfunction

   // Advance the shadow extraction by one text byte and queue the result it causes.
   function automatic void extract_byte(input logic [7:0] b, input logic is_last);
      result_type  r;
      logic        val;
      logic        done;
      logic        fnd;
      logic        take;
      logic [7:0]  ob;
      logic [63:0] mask;
      int          n;
      val  = 1'b0;
      done = 1'b0;
      fnd  = 1'b0;
      take = 1'b0;
      ob   = CHAR_NUL;
      if (scan_phase == DRAINING) begin
         if (is_last) close_text(1'b1);
         return;
      end
      if (b == CHAR_NUL) begin
         // A zero byte ends the text; a pending backslash is flushed with it.
         if (scan_phase == COPYING && escape_armed) begin
            val = 1'b1;
            ob  = CHAR_BACKSLASH;
            copy_count++;
         end
         done = 1'b1;
         fnd  = (scan_phase == COPYING) && (copy_count != 0);
         close_text(is_last);
      end else begin
         case (scan_phase)
            SEEK_KEY: begin
               n    = key_span();
               mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
               window = {window[55:0], b};
               if (window_fill < 8) window_fill++;
               if (window_fill >= n && (window & mask) == (key_reg & mask))
                  scan_phase = SEEK_COLON;
               if (is_last) begin
                  done = 1'b1;
                  close_text(1'b1);
               end
            end
            SEEK_COLON: begin
               if (b == CHAR_COLON) scan_phase = SEEK_QUOTE;
               if (is_last) begin
                  done = 1'b1;
                  close_text(1'b1);
               end
            end
            SEEK_QUOTE: begin
               if (b == CHAR_QUOTE) begin
                  if (max_chars_reg == 0) begin
                     done = 1'b1;
                     close_text(is_last);
                  end else begin
                     scan_phase = COPYING;
                  end
               end
               if (!done && is_last) begin
                  done = 1'b1;
                  close_text(1'b1);
               end
            end
            default: begin
               // Copying: escapes pass the next byte, an unescaped quote stops.
               if (escape_armed) begin
                  escape_armed = 1'b0;
                  take = 1'b1;
               end else if (b == CHAR_BACKSLASH) begin
                  if (is_last) take = 1'b1;
                  else escape_armed = 1'b1;
               end else if (b == CHAR_QUOTE) begin
                  done = 1'b1;
                  fnd  = (copy_count != 0);
                  close_text(is_last);
               end else begin
                  take = 1'b1;
               end
               if (take) begin
                  val = 1'b1;
                  ob  = b;
                  copy_count++;
                  if (copy_count >= max_chars_reg || is_last) begin
                     done = 1'b1;
                     fnd  = 1'b1;
                     close_text(is_last);
                  end
               end else if (!done && is_last) begin
                  done = 1'b1;
                  fnd  = (copy_count != 0);
                  close_text(1'b1);
               end
            end
         endcase
      end
      if (val || done) begin
         r.out_byte   = ob;
         r.byte_valid = val;
         r.done_res   = done;
         r.found      = done && fnd;
         owed_q.push_back(r);
      end
   endfunction

   // Result side: random stall bursts while gaps are enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   function automatic void compare_field(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
      end
   endfunction

   // Outputs are stable at the falling edge; an item seen here is taken at the next rise.
   always @(negedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_done_res) begin
            texts_closed++;
            if (rsp_found) strings_found++;
         end
         if (owed_q.size() == 0) begin
            errors++;
            $display({"%0t: result item with nothing expected, ",
                      "actual byte=%02h valid=%0b done=%0b found=%0b"},
                     $time, rsp_out_byte, rsp_byte_valid, rsp_done_res, rsp_found);
         end else begin
            want = owed_q.pop_front();
            compare_field("out_byte", want.out_byte, rsp_out_byte);
            compare_field("byte_valid", 8'(want.byte_valid), 8'(rsp_byte_valid));
            compare_field("done_res", 8'(want.done_res), 8'(rsp_done_res));
            compare_field("found", 8'(want.found), 8'(rsp_found));
         end
      end
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d result items outstanding",
                  $time, owed_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Send one text byte and wait until the block takes it.
   task automatic send_byte(input logic [8:0] entry);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= entry[7:0];
      req_last    <= entry[8];
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      extract_byte(entry[7:0], entry[8]);
      bytes_sent++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_byte(text_q[i]);
      text_q.delete();
   endtask

   function automatic void add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back({1'b0, s[i]});
   endfunction

   // Mark the final byte of the text as last.
   function automatic void end_text();
      if (text_q.size() == 0) text_q.push_back({1'b0, 8'($urandom_range(1, 255))});
      text_q[text_q.size() - 1][8] = 1'b1;
   endfunction

   // Stop sending and let every owed result come out before anything else happens.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (owed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_KEY_BYTES:  key_reg = data;
         REG_KEY_LENGTH: key_len_reg = data[3:0];
         REG_MAX_CHARS:  max_chars_reg = data[15:0];
         default: ;
      endcase
   endtask

   task automatic set_key(input string s);
      logic [63:0] kb;
      kb = '0;
      for (int i = 0; i < s.len(); i++) kb = {kb[55:0], s[i]};
      write_reg(REG_KEY_BYTES, kb);
      write_reg(REG_KEY_LENGTH, 64'(s.len()));
   endtask

   // Random key, key length and copy limit, extremes included.
   task automatic pick_config();
      logic [63:0] kb;
      logic [63:0] data;
      logic [3:0]  kl;
      logic [15:0] mc;
      kb = {$urandom, $urandom};
      for (int i = 0; i < 8; i++)
         if ($urandom_range(0, 3) != 0) kb[8 * i +: 8] = 8'($urandom_range(97, 122));
      if ($urandom_range(0, 9) == 0) kb = '1;
      write_reg(REG_KEY_BYTES, kb);
      case ($urandom_range(0, 9))
         0:       kl = 4'd0;
         1:       kl = 4'($urandom_range(9, 15));
         2:       kl = 4'd8;
         default: kl = 4'($urandom_range(1, 8));
      endcase
      data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
      data[3:0] = kl;
      write_reg(REG_KEY_LENGTH, data);
      case ($urandom_range(0, 11))
         0:       mc = 16'd0;
         1:       mc = 16'd1;
         2:       mc = 16'hFFFF;
         3:       mc = 16'd255;
         default: mc = 16'($urandom_range(2, 10));
      endcase
      data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
      data[15:0] = mc;
      write_reg(REG_MAX_CHARS, data);
      configs_used++;
   endtask

   function automatic logic [7:0] noise_byte();
      if ($urandom_range(0, 39) == 0) return CHAR_NUL;
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] string_byte();
      case ($urandom_range(0, 19))
         0, 1, 2: return CHAR_BACKSLASH;
         3:       return CHAR_QUOTE;
         4:       return ($urandom_range(0, 1) == 0) ? CHAR_NUL : 8'hFF;
         5, 6, 7, 8, 9: return 8'($urandom_range(1, 255));
         default: return 8'($urandom_range(97, 122));
      endcase
   endfunction

   // Mostly well-formed key/colon/quote/string texts; some lose a piece or are cut short.
   task automatic build_random_text();
      int kind;
      int n;
      int cut;
      kind = $urandom_range(0, 19);
      repeat ($urandom_range(0, 3)) text_q.push_back({1'b0, noise_byte()});
      if (kind != 0) begin
         n = key_span();
         for (int i = n - 1; i >= 0; i--) text_q.push_back({1'b0, key_reg[8 * i +: 8]});
         if (kind == 1)
            text_q[text_q.size() - 1 - $urandom_range(0, n - 1)] =
               {1'b0, 8'($urandom_range(1, 255))};
      end
      if ($urandom_range(0, 2) == 0) text_q.push_back({1'b0, 8'h20});
      if (kind != 2) text_q.push_back({1'b0, CHAR_COLON});
      if ($urandom_range(0, 2) == 0) text_q.push_back({1'b0, 8'h20});
      if (kind != 3) text_q.push_back({1'b0, CHAR_QUOTE});
      repeat ($urandom_range(0, ($urandom_range(0, 7) == 0) ? 24 : 6))
         text_q.push_back({1'b0, string_byte()});
      if (kind != 4) text_q.push_back({1'b0, CHAR_QUOTE});
      repeat ($urandom_range(0, 3)) text_q.push_back({1'b0, noise_byte()});
      if (kind == 5 && text_q.size() > 1) begin
         cut = $urandom_range(1, text_q.size() - 1);
         while (text_q.size() > cut) void'(text_q.pop_back());
      end
      end_text();
   endtask

   // Groups of random texts, each group under a fresh configuration.
   task automatic stream_texts(input int byte_goal, input bit with_gaps);
      while (bytes_sent < byte_goal) begin
         drain_block();
         pick_config();
         repeat ($urandom_range(4, 12)) begin
            idle_on = with_gaps && ($urandom_range(0, 4) != 0);
            build_random_text();
            send_text();
         end
      end
      drain_block();
   endtask

   // The reset key is a single zero byte, which can never match.
   task automatic test_default_config();
      idle_on = 1'b1;
      text_q.push_back({1'b1, 8'hFF});
      send_text();
      drain_block();
   endtask

   // Escaped bytes, a backslash before a zero byte or at the end of the text.
   task automatic test_escapes();
      set_key("k");
      add_str("k:\"a\\");
      text_q.push_back({1'b0, CHAR_NUL});
      add_str("z");
      end_text();
      send_text();
      add_str("k:\"\\\"");
      end_text();
      send_text();
      add_str("k:\"\\");
      end_text();
      send_text();
      drain_block();
   endtask

   // A zero copy limit closes at the opening quote; a limit of one stops after a byte.
   task automatic test_copy_limits();
      write_reg(REG_MAX_CHARS, 64'd0);
      add_str("k:\"");
      end_text();
      send_text();
      drain_block();
      write_reg(REG_MAX_CHARS, 64'd1);
      write_reg(REG_KEY_LENGTH, 64'd0);
      add_str("k:\"ab");
      end_text();
      send_text();
      drain_block();
   endtask

   task automatic test_random_texts();
      stream_texts(bytes_sent + RANDOM_BYTES - STEADY_BYTES, 1'b1);
   endtask

   // Closing stretch at full rate, with no gaps or stalls on either side.
   task automatic test_back_to_back();
      stream_texts(bytes_sent + STEADY_BYTES, 1'b0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_config();
      test_escapes();
      test_copy_limits();
      test_random_texts();
      test_back_to_back();
      drain_block();
      if (owed_q.size() != 0) begin
         errors++;
         $display("%0t: expected %0d more result items, actual 0", $time, owed_q.size());
      end
      $display("Run covered %0d text bytes over %0d random configurations.",
               bytes_sent, configs_used);
      $display("Checked %0d result items; %0d texts closed, %0d of them with a string found.",
               results_seen, texts_closed, strings_found);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
